// ----- rtl/lzos_pkg.sv -----
`default_nettype none

package lzos_pkg;

  localparam int DEF_NUM_LAYERS = 256;
  localparam int MAX_IDX_W      = 10;
  localparam int GROUP_W        = 16;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 32;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_SET   = 2'd1,
    OP_FREE  = 2'd2,
    OP_PEEK  = 2'd3
  } op_e;

  typedef struct packed {
    logic                 commit;
    logic                 up;
    logic                 dn;
    logic                 wr;
    logic [MAX_IDX_W-1:0] lo;
    logic [MAX_IDX_W-1:0] hi;
    logic [MAX_IDX_W-1:0] wpos;
  } shift_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/lzos_cell.sv -----
`default_nettype none

module lzos_cell
  import lzos_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 8,
  parameter int VC_W  = 9
) (
  input  wire              clk_i,
  input  shift_ctrl_t      ctrl_i,
  input  wire  [IDX_W-1:0] left_i,
  input  wire  [IDX_W-1:0] right_i,
  input  wire  [IDX_W-1:0] wslot_i,
  input  wire  [IDX_W-1:0] key_i,
  input  wire  [VC_W-1:0]  vis_i,
  output logic             match_o,
  output logic [IDX_W-1:0] data_o
);

  localparam logic [MAX_IDX_W-1:0] POS  = MAX_IDX_W'(IDX);
  localparam logic [MAX_IDX_W-1:0] PREV = MAX_IDX_W'((IDX == 0) ? 0 : IDX - 1);
  localparam logic [VC_W-1:0]      POS_VC = VC_W'(IDX);

  logic [IDX_W-1:0] data_q;
  logic [IDX_W-1:0] data_d;
  logic             take_left;
  logic             take_right;

  assign take_left  = ctrl_i.up && (IDX != 0) && (PREV >= ctrl_i.lo) && (PREV <= ctrl_i.hi);
  assign take_right = ctrl_i.dn && (POS >= ctrl_i.lo) && (POS < ctrl_i.hi);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.commit) begin
      priority if (ctrl_i.wr && (POS == ctrl_i.wpos)) begin
        data_d = wslot_i;
      end else if (take_left) begin
        data_d = left_i;
      end else if (take_right) begin
        data_d = right_i;
      end else begin
        data_d = data_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign match_o = (POS_VC < vis_i) && (data_q == key_i);
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/lzos_free.sv -----
`default_nettype none

module lzos_free
  import lzos_pkg::*;
#(
  parameter int NUM_LAYERS = DEF_NUM_LAYERS,
  parameter int IDX_W      = 8
) (
  input  wire                   clk_i,
  input  wire  [NUM_LAYERS-1:0] in_use_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      idx_o
);

  localparam int NG   = (NUM_LAYERS + GROUP_W - 1) / GROUP_W;
  localparam int PAD  = NG * GROUP_W;
  localparam int GI_W = $clog2(GROUP_W);

  logic [PAD-1:0]  free_v;
  logic [NG-1:0]   gfree_d;
  logic [NG-1:0]   gfree_q;
  logic [GI_W-1:0] gidx_d [NG];
  logic [GI_W-1:0] gidx_q [NG];

  assign free_v = PAD'(NUM_LAYERS'(~in_use_i));

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gfree_d[g] = |free_v[g*GROUP_W +: GROUP_W];
      gidx_d[g]  = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
        if (free_v[g*GROUP_W + b]) begin
          gidx_d[g] = GI_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gfree_q <= gfree_d;
    gidx_q  <= gidx_d;
  end

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (gfree_q[g]) begin
        found_o = 1'b1;
        idx_o   = IDX_W'(g * GROUP_W + int'(gidx_q[g]));
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/layer_z_order_stack_core.sv -----
// Layer stacking-order manager for a fixed pool of display layers.
// Requests arrive as words on the s_axis channel: op in bits 1:0, slot in
// bits 9:2 and the signed requested height in bits 18:10. Each request
// yields exactly one result word on the m_axis channel: slot_out in bits 7:0,
// ok in bit 8, the signed applied height in bits 17:9 and the visible count
// in bits 26:18.
// The stacking order is held in a row of cells, one per height. A request
// is accepted when all cells compare their slot against the request at
// once and its fields are registered; it is committed when the output
// register is free, and every cell then takes its neighbor's entry as
// needed. The commit also loads the result into the output register, and
// no new request is taken before the commit of the last one.
// A new request is taken while an earlier result waits in the output
// register; when the receiver stalls, the commit waits until the output
// register is free, and no further request is taken until then.
// Reset frees every slot, hides every layer and clears the visible count;
// the block is ready to accept a request as soon as reset is released.

`default_nettype none

module layer_z_order_stack_core
  import lzos_pkg::*;
#(
  parameter int NUM_LAYERS = DEF_NUM_LAYERS
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // op[1:0], slot[9:2], new_height[18:10], zero fill above.
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  // slot_out[7:0], ok[8], applied_height[17:9], visible_count[26:18], zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int IDX_W = $clog2(NUM_LAYERS);
  localparam int VC_W  = $clog2(NUM_LAYERS + 1);
  localparam int HW    = IDX_W + 1;
  localparam int CW    = ((HW > 9) ? HW : 9) + 1;
  localparam logic signed [CW-1:0] NEG1 = '1;

  op_e                    in_op;
  logic [7:0]             in_slot;
  logic signed [8:0]      in_height;
  logic [IDX_W-1:0]       in_idx;
  logic                   in_valid;
  logic                   accept;

  logic [IDX_W-1:0]       chain [NUM_LAYERS+2];
  logic [NUM_LAYERS-1:0]  hit;
  logic [IDX_W-1:0]       hit_idx;
  logic signed [HW-1:0]   old_lookup;

  logic                   busy_q;
  logic                   m_valid_q;
  logic [VC_W-1:0]        vis_q;
  logic [VC_W-1:0]        vis_d;
  logic [NUM_LAYERS-1:0]  in_use_q;
  logic [NUM_LAYERS-1:0]  in_use_d;

  op_e                    op_q;
  logic [7:0]             slot_q;
  logic signed [8:0]      req_q;
  logic signed [HW-1:0]   old_q;
  logic                   inuse_q;
  logic                   valid_q;
  logic [OUT_DATA_W-1:0]  out_q;
  logic [OUT_DATA_W-1:0]  out_d;

  logic                   found;
  logic [IDX_W-1:0]       free_idx;
  logic                   commit;
  shift_ctrl_t            ctrl;

  logic signed [CW-1:0]   top_s;
  logic signed [CW-1:0]   old_s;
  logic signed [CW-1:0]   req_s;
  logic signed [CW-1:0]   limit_s;
  logic signed [CW-1:0]   hc;
  logic signed [CW-1:0]   hn;
  logic                   set_ok;
  logic                   do_set;
  logic [7:0]             res_slot;
  logic                   res_ok;
  logic [8:0]             res_height;

  assign in_op     = op_e'(s_axis_tdata_i[1:0]);
  assign in_slot   = s_axis_tdata_i[9:2];
  assign in_height = signed'(s_axis_tdata_i[18:10]);
  assign in_idx    = IDX_W'(in_slot);
  assign in_valid  = int'(in_slot) < NUM_LAYERS;

  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && !busy_q;
  assign commit          = busy_q && (!m_valid_q || m_axis_tready_i);

  assign chain[0]            = '0;
  assign chain[NUM_LAYERS+1] = '0;

  for (genvar k = 0; k < NUM_LAYERS; k++) begin : g_cell
    lzos_cell #(
      .IDX   (k),
      .IDX_W (IDX_W),
      .VC_W  (VC_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (chain[k]),
      .right_i (chain[k+2]),
      .wslot_i (IDX_W'(slot_q)),
      .key_i   (in_idx),
      .vis_i   (vis_q),
      .match_o (hit[k]),
      .data_o  (chain[k+1])
    );
  end

  lzos_free #(
    .NUM_LAYERS (NUM_LAYERS),
    .IDX_W      (IDX_W)
  ) u_free (
    .clk_i    (clk_i),
    .in_use_i (in_use_q),
    .found_o  (found),
    .idx_o    (free_idx)
  );

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < NUM_LAYERS; k++) begin
      if (hit[k]) begin
        hit_idx = hit_idx | IDX_W'(k);
      end
    end
    old_lookup = (in_valid && (|hit)) ? signed'({1'b0, hit_idx}) : '1;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_op;
      slot_q  <= in_slot;
      req_q   <= in_height;
      old_q   <= old_lookup;
      inuse_q <= in_valid && in_use_q[in_idx];
      valid_q <= in_valid;
    end
  end

  always_comb begin
    top_s   = signed'(CW'(vis_q)) - CW'(1);
    old_s   = CW'(old_q);
    req_s   = CW'(req_q);
    limit_s = old_q[HW-1] ? top_s + CW'(1) : top_s;
    hc      = (req_s > limit_s) ? limit_s : req_s;
    hc      = (hc < NEG1) ? NEG1 : hc;
    set_ok  = valid_q && inuse_q;
    do_set  = set_ok && ((op_q == OP_SET) || ((op_q == OP_FREE) && !old_q[HW-1]));
    hn      = (op_q == OP_SET) ? hc : NEG1;

    ctrl        = '0;
    ctrl.commit = commit;
    vis_d       = vis_q;
    if (do_set) begin
      if (old_s > hn) begin
        if (!hn[CW-1]) begin
          ctrl.up   = 1'b1;
          ctrl.lo   = MAX_IDX_W'(hn);
          ctrl.hi   = MAX_IDX_W'(old_s - CW'(1));
          ctrl.wr   = 1'b1;
          ctrl.wpos = MAX_IDX_W'(hn);
        end else begin
          ctrl.dn = 1'b1;
          ctrl.lo = MAX_IDX_W'(old_s);
          ctrl.hi = MAX_IDX_W'(top_s);
          vis_d   = vis_q - VC_W'(1);
        end
      end else if (old_s < hn) begin
        if (!old_q[HW-1]) begin
          ctrl.dn   = 1'b1;
          ctrl.lo   = MAX_IDX_W'(old_s);
          ctrl.hi   = MAX_IDX_W'(hn);
          ctrl.wr   = 1'b1;
          ctrl.wpos = MAX_IDX_W'(hn);
        end else begin
          ctrl.up   = 1'b1;
          ctrl.lo   = MAX_IDX_W'(hn);
          ctrl.hi   = MAX_IDX_W'(top_s);
          ctrl.wr   = 1'b1;
          ctrl.wpos = MAX_IDX_W'(hn);
          vis_d     = vis_q + VC_W'(1);
        end
      end
    end

    in_use_d = in_use_q;
    unique case (op_q)
      OP_ALLOC: begin
        res_slot   = found ? 8'(free_idx) : 8'd0;
        res_ok     = found;
        res_height = 9'(NEG1);
        if (found) begin
          in_use_d[free_idx] = 1'b1;
        end
      end
      OP_SET: begin
        res_slot   = slot_q;
        res_ok     = set_ok;
        res_height = set_ok ? 9'(hn) : 9'(NEG1);
      end
      OP_FREE: begin
        res_slot   = slot_q;
        res_ok     = set_ok;
        res_height = 9'(NEG1);
        if (set_ok) begin
          in_use_d[IDX_W'(slot_q)] = 1'b0;
        end
      end
      OP_PEEK: begin
        res_slot   = slot_q;
        res_ok     = 1'b0;
        res_height = valid_q ? 9'(old_q) : 9'(NEG1);
      end
      default: begin
        res_slot   = slot_q;
        res_ok     = 1'b0;
        res_height = 9'(NEG1);
      end
    endcase

    out_d = {5'b0, 9'(vis_d), res_height, res_ok, res_slot};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
      vis_q     <= '0;
      in_use_q  <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      if (commit) begin
        m_valid_q <= 1'b1;
        vis_q     <= vis_d;
        in_use_q  <= in_use_d;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/lzos_checker.sv -----
`default_nettype none

module lzos_checker
  import lzos_pkg::*;
#(
  parameter int NUM_LAYERS = DEF_NUM_LAYERS
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid_i,
  input wire                  s_axis_tready_o,
  input wire [IN_DATA_W-1:0]  s_axis_tdata_i,
  input wire                  m_axis_tvalid_o,
  input wire                  m_axis_tready_i,
  input wire [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // A stalled result word must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // Each accepted word occupies the block for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted in back-to-back cycles");

  // The visible count never exceeds the pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> int'(m_axis_tdata_o[26:18]) <= NUM_LAYERS)
    else $error("visible count beyond pool size");

  // A shown height always comes with at least one visible layer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[8] && !m_axis_tdata_o[17] |-> m_axis_tdata_o[26:18] != 9'd0)
    else $error("shown height reported with no visible layer");

endmodule

bind layer_z_order_stack_core lzos_checker #(.NUM_LAYERS(NUM_LAYERS)) u_lzos_checker (.*);

`default_nettype wire

// ----- tb/layer_order_checker.sv -----
module layer_order_checker
  import lzos_pkg::*;
#(
  parameter int NUM_LAYERS = DEF_NUM_LAYERS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // op[1:0], slot[9:2], new_height[18:10], zero fill above.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // slot_out[7:0], ok[8], applied_height[17:9], visible_count[26:18], zero fill.
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  output int                    mismatch_count_o,
  output int                    outstanding_o
);

  typedef struct packed {
    logic [8:0]        visible;
    logic signed [8:0] height;
    logic              ok;
    logic [7:0]        slot;
  } layer_result_t;

  bit            in_use_q [NUM_LAYERS];
  int            height_q [NUM_LAYERS];
  int            order_q  [NUM_LAYERS];
  int            top_q;
  layer_result_t expected_results [$];

  initial begin
    for (int i = 0; i < NUM_LAYERS; i++) begin
      in_use_q[i] = 1'b0;
      height_q[i] = -1;
      order_q[i]  = 0;
    end
    top_q            = -1;
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("layer_order_checker: %s got %0d, want %0d", what, got, want);
    mismatch_count_o++;
  endtask

  // Moves one layer to a new height; the layers it passes shift by one place.
  function automatic void move_layer(input int s, input int h);
    int old;
    int lim;
    int k;
    old = height_q[s];
    lim = (old >= 0) ? top_q : top_q + 1;
    if (h > lim) h = lim;
    if (h < -1) h = -1;
    height_q[s] = h;
    if (old > h) begin
      if (h >= 0) begin
        for (k = old; k > h; k--) begin
          order_q[k] = order_q[k-1];
          height_q[order_q[k]] = k;
        end
        order_q[h] = s;
      end else begin
        for (k = old; k < top_q; k++) begin
          order_q[k] = order_q[k+1];
          height_q[order_q[k]] = k;
        end
        top_q--;
      end
    end else if (old < h) begin
      if (old >= 0) begin
        for (k = old; k < h; k++) begin
          order_q[k] = order_q[k+1];
          height_q[order_q[k]] = k;
        end
        order_q[h] = s;
      end else begin
        for (k = top_q; k >= h; k--) begin
          order_q[k+1] = order_q[k];
          height_q[order_q[k+1]] = k + 1;
        end
        order_q[h] = s;
        top_q++;
      end
    end
  endfunction

  function automatic layer_result_t apply_layer_request(input op_e op, input logic [7:0] slot,
                                                        input logic signed [8:0] hreq);
    layer_result_t r;
    int            s;
    int            i;
    bit            in_pool;
    s       = slot;
    in_pool = (s < NUM_LAYERS);
    r.slot   = slot;
    r.ok     = 1'b0;
    r.height = 9'(-1);
    case (op)
      OP_ALLOC: begin
        r.slot = '0;
        for (i = 0; i < NUM_LAYERS; i++) begin
          if (!in_use_q[i]) begin
            in_use_q[i] = 1'b1;
            height_q[i] = -1;
            r.slot      = 8'(i);
            r.ok        = 1'b1;
            break;
          end
        end
      end
      OP_SET: begin
        if (in_pool && in_use_q[s]) begin
          move_layer(s, hreq);
          r.height = 9'(height_q[s]);
          r.ok     = 1'b1;
        end
      end
      OP_FREE: begin
        if (in_pool && in_use_q[s]) begin
          if (height_q[s] >= 0) move_layer(s, -1);
          in_use_q[s] = 1'b0;
          r.ok        = 1'b1;
        end
      end
      default: begin
        if (in_pool) r.height = 9'(height_q[s]);
      end
    endcase
    r.visible = 9'(top_q + 1);
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    layer_result_t got;
    layer_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[26:0];
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding, slot_out", got.slot, -1);
        end else begin
          want = expected_results.pop_front();
          if (got.slot !== want.slot) report_mismatch("slot_out", got.slot, want.slot);
          if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
          if (got.height !== want.height)
            report_mismatch("applied_height", int'(got.height), int'(want.height));
          if (got.visible !== want.visible)
            report_mismatch("visible_count", got.visible, want.visible);
          if (m_axis_tdata_i[OUT_DATA_W-1:27] !== '0)
            report_mismatch("fill bits", m_axis_tdata_i[OUT_DATA_W-1:27], 0);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_results.push_back(apply_layer_request(op_e'(s_axis_tdata_i[1:0]),
                                                       s_axis_tdata_i[9:2],
                                                       s_axis_tdata_i[18:10]));
      end
    end
    outstanding_o = expected_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import lzos_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int TAIL_CYCLES      = 8;
  localparam int RANDOM_PER_PHASE = 500;

  logic                  clk;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int cycles      = 0;
  int tx_idle_pct = 20;
  int rx_idle_pct = 45;
  bit slot_taken [DEF_NUM_LAYERS];

  int alloc_cut [3] = '{65, 20, 35};
  int set_cut   [3] = '{87, 70, 75};
  int free_cut  [3] = '{95, 95, 95};
  int tx_pct    [3] = '{20, 45, 0};
  int rx_pct    [3] = '{45, 20, 0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  layer_z_order_stack_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  layer_order_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_word(input logic [IN_DATA_W-1:0] w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Tracks which slots are taken so that most set and free words hit live layers.
  task automatic issue(input op_e op, input logic [7:0] slot, input logic signed [8:0] h);
    int i;
    if (op == OP_ALLOC) begin
      for (i = 0; i < DEF_NUM_LAYERS; i++) begin
        if (!slot_taken[i]) begin
          slot_taken[i] = 1'b1;
          break;
        end
      end
    end else if (op == OP_FREE) begin
      slot_taken[slot] = 1'b0;
    end
    send_word({{(IN_DATA_W-19){1'b0}}, h, slot, op});
  endtask

  function automatic logic [7:0] pick_slot();
    int start;
    int k;
    start = $urandom_range(0, DEF_NUM_LAYERS - 1);
    if ($urandom_range(0, 99) < 85) begin
      for (k = 0; k < DEF_NUM_LAYERS; k++) begin
        if (slot_taken[(start + k) % DEF_NUM_LAYERS]) return 8'((start + k) % DEF_NUM_LAYERS);
      end
    end
    return 8'(start);
  endfunction

  function automatic logic signed [8:0] pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return -9'sd1;
    if (r < 40) return 9'($urandom_range(0, 511));
    if (r < 45) return 9'sd255;
    if (r < 70) return 9'($urandom_range(0, 16));
    return 9'($urandom_range(0, 255));
  endfunction

  initial begin
    int  phase;
    int  n;
    int  r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(OP_PEEK,  8'd0,   -9'sd1);
    issue(OP_SET,   8'd5,   9'sd3);
    issue(OP_FREE,  8'd7,   9'sd0);
    issue(OP_ALLOC, 8'd0,   9'sd0);
    issue(OP_ALLOC, 8'd200, -9'sd256);
    issue(OP_ALLOC, 8'd0,   9'sd0);
    issue(OP_ALLOC, 8'd255, 9'sd255);
    issue(OP_SET,   8'd0,   9'sd255);
    issue(OP_SET,   8'd1,   -9'sd256);
    issue(OP_SET,   8'd1,   9'sd255);
    issue(OP_SET,   8'd2,   9'sd0);
    issue(OP_SET,   8'd3,   9'sd1);
    issue(OP_SET,   8'd0,   9'sd255);
    issue(OP_SET,   8'd2,   -9'sd1);
    issue(OP_PEEK,  8'd3,   9'sd255);
    issue(OP_PEEK,  8'd255, -9'sd1);
    issue(OP_SET,   8'd3,   9'sd3);
    issue(OP_SET,   8'd1,   9'sd0);
    issue(OP_FREE,  8'd0,   -9'sd1);
    issue(OP_FREE,  8'd2,   9'sd0);
    issue(OP_FREE,  8'd2,   9'sd0);
    issue(OP_SET,   8'd255, 9'sd0);
    issue(OP_ALLOC, 8'd0,   9'sd0);
    issue(OP_PEEK,  8'd1,   -9'sd2);

    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = tx_pct[phase];
      rx_idle_pct = rx_pct[phase];
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < alloc_cut[phase]) begin
          issue(OP_ALLOC, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
        end else if (r < set_cut[phase]) begin
          issue(OP_SET, pick_slot(), pick_height());
        end else if (r < free_cut[phase]) begin
          issue(OP_FREE, pick_slot(), 9'($urandom_range(0, 511)));
        end else begin
          issue(OP_PEEK, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
        end
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lzos_pkg.sv
rtl/lzos_cell.sv
rtl/lzos_free.sv
rtl/layer_z_order_stack_core.sv
rtl/lzos_checker.sv
tb/layer_order_checker.sv
tb/tb_top.sv
